### rtl/rae_pkg.sv
package rae_pkg;

    localparam int NUM_REGS_DEF = 8;
    localparam int IDX_W        = 3;
    localparam int IMM_W        = 25;
    localparam int WORD_W       = 32;
    localparam int Q_DEPTH      = 2;

    typedef enum logic [2:0] {
        OP_CMOVE = 3'd0,
        OP_ADD   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_NAND  = 3'd4,
        OP_LOADI = 3'd5,
        OP_NOP   = 3'd6
    } op_e_t;

    typedef struct packed {
        op_e_t            op;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic [IMM_W-1:0] imm;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RDB,
        B_RDC,
        B_RDA,
        B_EXEC,
        B_DIV,
        B_WB
    } back_state_t;

endpackage

### rtl/rae_front.sv
module rae_front
    import rae_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        q_full,
    output logic        q_push,
    output job_t        q_job
);

    logic  hold_valid_reg;
    logic  hold_valid_next;
    job_t  hold_job_reg;
    job_t  dec_job;
    logic  s_accept;

    always_comb begin
        dec_job.a   = s_axis_tdata[5:3];
        dec_job.b   = s_axis_tdata[8:6];
        dec_job.c   = s_axis_tdata[11:9];
        dec_job.imm = s_axis_tdata[36:12];
        if (s_axis_tdata[2:0] <= OP_LOADI) begin
            dec_job.op = op_e_t'(s_axis_tdata[2:0]);
        end else begin
            dec_job.op = OP_NOP;
        end
    end

    assign q_push        = hold_valid_reg && !q_full;
    assign s_axis_tready = !hold_valid_reg || !q_full;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign q_job         = hold_job_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (s_accept) begin
            hold_valid_next = 1'b1;
        end else if (q_push) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            hold_job_reg <= dec_job;
        end
    end

endmodule

### rtl/rae_queue.sv
module rae_queue
    import rae_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    job_t            slot_reg [Q_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full    = (count_reg == CW'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("queue pop while empty");

endmodule

### rtl/rae_back.sv
module rae_back
    import rae_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    input  job_t        q_job,
    output logic        q_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser
);

    localparam int AW = $clog2(NUM_REGS);

    back_state_t         state_reg;
    back_state_t         state_next;
    job_t                job_reg;
    logic [WORD_W-1:0]   mem [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [WORD_W-1:0]   rd_data_reg;
    logic                rd_ok_reg;
    logic [IDX_W-1:0]    rd_idx;
    logic [WORD_W-1:0]   rd_val;
    logic [WORD_W-1:0]   va_reg;
    logic [WORD_W-1:0]   vb_reg;
    logic [WORD_W-1:0]   vc_reg;
    logic [WORD_W-1:0]   res_reg;
    logic                wr_reg;
    logic                fault_reg;
    logic [2*WORD_W-1:0] mul_full;
    logic [WORD_W-1:0]   rem_reg;
    logic [WORD_W-1:0]   quo_reg;
    logic [4:0]          cnt_reg;
    logic [WORD_W:0]     rem_sh;
    logic [WORD_W+1:0]   diff;
    logic                sub_ok;
    logic [WORD_W-1:0]   rem_step;
    logic [WORD_W-1:0]   quo_step;
    logic                a_ok;
    logic                wr_eff;
    logic                out_free;
    logic                out_load;
    logic                mem_we;
    logic                m_valid_reg;
    logic [IDX_W-1:0]    m_index_reg;
    logic [WORD_W-1:0]   m_value_reg;
    logic                m_write_reg;
    logic                m_fault_reg;

    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [IDX_W+AW-1:0] wide;
        wide = {{AW{1'b0}}, idx};
        return wide[AW-1:0];
    endfunction

    function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
        return (32'(idx) < 32'(NUM_REGS));
    endfunction

    always_comb begin
        case (state_reg)
            B_IDLE:  rd_idx = q_job.b;
            B_RDB:   rd_idx = job_reg.c;
            B_RDC:   rd_idx = job_reg.a;
            default: rd_idx = job_reg.a;
        endcase
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[to_addr(rd_idx)];
        rd_ok_reg   <= idx_ok(rd_idx) && valid_reg[to_addr(rd_idx)];
    end

    assign rd_val   = rd_ok_reg ? rd_data_reg : '0;
    assign a_ok     = idx_ok(job_reg.a);
    assign wr_eff   = wr_reg && a_ok;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign out_load = (state_reg == B_WB) && out_free;
    assign mem_we   = out_load && wr_eff;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[to_addr(job_reg.a)] <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[to_addr(job_reg.a)] <= 1'b1;
        end
    end

    assign mul_full = vb_reg * vc_reg;
    assign rem_sh   = {rem_reg, quo_reg[WORD_W-1]};
    assign diff     = {1'b0, rem_sh} - {2'b00, vc_reg};
    assign sub_ok   = !diff[WORD_W+1];
    assign rem_step = sub_ok ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
    assign quo_step = {quo_reg[WORD_W-2:0], sub_ok};

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    state_next = B_RDB;
                end
            end
            B_RDB: state_next = B_RDC;
            B_RDC: state_next = B_RDA;
            B_RDA: state_next = B_EXEC;
            B_EXEC: begin
                if (job_reg.op == OP_DIV && vc_reg != '0) begin
                    state_next = B_DIV;
                end else begin
                    state_next = B_WB;
                end
            end
            B_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = B_WB;
                end
            end
            B_WB: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (q_pop) begin
                    job_reg <= q_job;
                end
            end
            B_RDB: vb_reg <= rd_val;
            B_RDC: vc_reg <= rd_val;
            B_RDA: va_reg <= rd_val;
            B_EXEC: begin
                fault_reg <= 1'b0;
                wr_reg    <= 1'b1;
                case (job_reg.op)
                    OP_CMOVE: begin
                        res_reg <= vb_reg;
                        wr_reg  <= (vc_reg != '0);
                    end
                    OP_ADD:   res_reg <= vb_reg + vc_reg;
                    OP_MUL:   res_reg <= mul_full[WORD_W-1:0];
                    OP_DIV: begin
                        wr_reg    <= (vc_reg != '0);
                        fault_reg <= (vc_reg == '0);
                        quo_reg   <= vb_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= 5'd31;
                    end
                    OP_NAND:  res_reg <= ~(vb_reg & vc_reg);
                    OP_LOADI: res_reg <= {{(WORD_W-IMM_W){1'b0}}, job_reg.imm};
                    default:  wr_reg  <= 1'b0;
                endcase
            end
            B_DIV: begin
                rem_reg <= rem_step;
                quo_reg <= quo_step;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    res_reg <= quo_step;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_index_reg <= job_reg.a;
            m_value_reg <= wr_eff ? res_reg : va_reg;
            m_write_reg <= wr_eff;
            m_fault_reg <= fault_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'd0, m_value_reg, m_index_reg};
    assign m_axis_tuser  = {m_fault_reg, m_write_reg};

    a_fault_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_fault_reg) |-> !m_write_reg)
        else $error("divide fault beat also reports a write");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DIV) |-> (job_reg.op == OP_DIV && vc_reg != '0))
        else $error("divider running without a non-zero divisor");

endmodule

### rtl/register_alu_execute_unit.sv
// Register ALU execute unit with an file of NUM_REGS 32-bit registers.
// Input beats arrive on s_axis: tdata carries req_type, reg_a, reg_b, reg_c
// and a 25-bit immediate. Each beat yields exactly one m_axis beat giving the
// destination index, its value after the operation, a write flag and a
// divide-by-zero flag, in input order.
// A front stage decodes each beat into a two-entry queue; the back end reads
// the sources and old destination through the single read port of the file
// one per cycle, executes, and writes back.
// A divide with a non-zero divisor takes its quotient from a radix-2 divider
// at one bit per cycle. The back end works on one item at a time and pops
// the next only after the last has been written back; meanwhile the queue
// and the front stage hold further beats.
// Reset clears all registers at once (valid bits) and empties the queue and
// the output register. When m_axis_tready is low the result holds in the
// output register, the back end finishes its next item and waits, and the
// queue then fills and s_axis_tready drops.
module register_alu_execute_unit
    import rae_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // req_type, reg_a, reg_b, reg_c, immediate
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // dest_index, dest_value
    output logic [1:0]  m_axis_tuser   // did_write, divide_fault
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    job_t q_in_job;
    job_t q_out_job;

    rae_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (q_in_job)
    );

    rae_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_in_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_out_job),
        .empty    (q_empty)
    );

    rae_back #(
        .NUM_REGS (NUM_REGS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_job         (q_out_job),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
